FILE: sv/spcb_pkg.sv
// shared types, command codes and saturating arithmetic for the path to cubic converter
`default_nettype none

package spcb_pkg;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int IN_TDATA_W  = 6 * COORD_W;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 8 * COORD_W;

  // ceil(2^(COORD_W+1) / 3), exact for magnitudes below 2^COORD_W
  localparam logic [COORD_W-1:0] RECIP3 = 32'hAAAA_AAAB;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef enum logic [2:0] {
    CMD_MOVE   = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_CUBIC  = 3'd2,
    CMD_SMOOTH = 3'd3,
    CMD_CLOSE  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       relative;
    coord_t     ctrl1_x;
    coord_t     ctrl1_y;
    coord_t     ctrl2_x;
    coord_t     ctrl2_y;
    coord_t     end_x;
    coord_t     end_y;
  } item_t;

  typedef struct packed {
    logic   line;
    coord_t ax;
    coord_t ay;
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    coord_t bx;
    coord_t by;
  } seg_t;

  typedef struct packed {
    seg_t  seg;
    logic  neg_x;
    logic  neg_y;
    prod_t prod_x;
    prod_t prod_y;
  } div_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/spcb_front.sv
// command decode, relative to absolute conversion and path state registers
`default_nettype none

module spcb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire spcb_pkg::item_t item,
  input  wire logic          take,
  output spcb_pkg::seg_t     seg,
  output logic               emit
);
  import spcb_pkg::*;

  coord_t cur_x_r, cur_y_r, sub_x_r, sub_y_r, last_x_r, last_y_r;
  coord_t cur_x_nxt, cur_y_nxt, sub_x_nxt, sub_y_nxt, last_x_nxt, last_y_nxt;
  coord_t c1x, c1y, c2x, c2y, ex, ey, refl_x, refl_y;
  logic   upd_cur, upd_sub, upd_last;

  always_comb begin
    c1x = item.relative ? sat_add(item.ctrl1_x, cur_x_r) : item.ctrl1_x;
    c1y = item.relative ? sat_add(item.ctrl1_y, cur_y_r) : item.ctrl1_y;
    c2x = item.relative ? sat_add(item.ctrl2_x, cur_x_r) : item.ctrl2_x;
    c2y = item.relative ? sat_add(item.ctrl2_y, cur_y_r) : item.ctrl2_y;
    ex  = item.relative ? sat_add(item.end_x, cur_x_r) : item.end_x;
    ey  = item.relative ? sat_add(item.end_y, cur_y_r) : item.end_y;
    refl_x = sat_sub(sat_add(cur_x_r, cur_x_r), last_x_r);
    refl_y = sat_sub(sat_add(cur_y_r, cur_y_r), last_y_r);
  end

  always_comb begin
    seg.line = 1'b0;
    seg.ax   = cur_x_r;
    seg.ay   = cur_y_r;
    seg.p1x  = c1x;
    seg.p1y  = c1y;
    seg.p2x  = c2x;
    seg.p2y  = c2y;
    seg.bx   = ex;
    seg.by   = ey;
    emit     = 1'b0;
    upd_cur  = 1'b0;
    upd_sub  = 1'b0;
    upd_last = 1'b0;
    unique case (cmd_t'(item.req_type))
      CMD_MOVE: begin
        upd_cur = 1'b1;
        upd_sub = 1'b1;
      end
      CMD_LINE: begin
        emit     = 1'b1;
        seg.line = 1'b1;
        upd_cur  = 1'b1;
      end
      CMD_CUBIC: begin
        emit     = 1'b1;
        upd_cur  = 1'b1;
        upd_last = 1'b1;
      end
      CMD_SMOOTH: begin
        emit     = 1'b1;
        seg.p1x  = refl_x;
        seg.p1y  = refl_y;
        upd_cur  = 1'b1;
        upd_last = 1'b1;
      end
      CMD_CLOSE: begin
        // current point stays where it is
        emit     = 1'b1;
        seg.line = 1'b1;
        seg.bx   = sub_x_r;
        seg.by   = sub_y_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_x_nxt  = (take && upd_cur)  ? ex  : cur_x_r;
    cur_y_nxt  = (take && upd_cur)  ? ey  : cur_y_r;
    sub_x_nxt  = (take && upd_sub)  ? ex  : sub_x_r;
    sub_y_nxt  = (take && upd_sub)  ? ey  : sub_y_r;
    last_x_nxt = (take && upd_last) ? c2x : last_x_r;
    last_y_nxt = (take && upd_last) ? c2y : last_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      sub_x_r  <= '0;
      sub_y_r  <= '0;
      last_x_r <= '0;
      last_y_r <= '0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      sub_x_r  <= sub_x_nxt;
      sub_y_r  <= sub_y_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/spcb_div3.sv
// line delta and reciprocal multiply for the divide by three
`default_nettype none

module spcb_div3 (
  input  wire spcb_pkg::seg_t seg,
  output spcb_pkg::div_t      div
);
  import spcb_pkg::*;

  coord_t dx, dy;
  logic [COORD_W-1:0] mag_x, mag_y;

  always_comb begin
    dx    = sat_sub(seg.bx, seg.ax);
    dy    = sat_sub(seg.by, seg.ay);
    mag_x = dx[COORD_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    mag_y = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    div.seg    = seg;
    div.neg_x  = dx[COORD_W-1];
    div.neg_y  = dy[COORD_W-1];
    div.prod_x = PROD_W'(mag_x) * PROD_W'(RECIP3);
    div.prod_y = PROD_W'(mag_y) * PROD_W'(RECIP3);
  end

endmodule

`default_nettype wire

FILE: sv/spcb_line.sv
// quotient recovery and thirds-spaced control points for lines
`default_nettype none

module spcb_line (
  input  wire spcb_pkg::div_t div,
  output spcb_pkg::seg_t      seg
);
  import spcb_pkg::*;

  coord_t qx, qy, ux, uy;

  always_comb begin
    ux = {1'b0, div.prod_x[PROD_W-1:COORD_W+1]};
    uy = {1'b0, div.prod_y[PROD_W-1:COORD_W+1]};
    qx = div.neg_x ? -ux : ux;
    qy = div.neg_y ? -uy : uy;
    seg = div.seg;
    if (div.seg.line) begin
      seg.p1x = sat_add(div.seg.ax, qx);
      seg.p1y = sat_add(div.seg.ay, qy);
      seg.p2x = sat_sub(div.seg.bx, qx);
      seg.p2y = sat_sub(div.seg.by, qy);
    end
  end

endmodule

`default_nettype wire

FILE: sv/svg_path_to_cubic_bezier.sv
// top level: path command stream in, cubic segment stream out
//
// in_*: one path command per transaction; tuser carries the command code and
// the relative flag, tdata the three coordinate pairs in signed Q16.16.
// out_*: one cubic segment (four points) per transaction. Move commands and
// unknown codes produce no output transaction.
// cfg_*: flip_y register, written on any cycle with cfg_wr_en high; applied to
// segments entering the output stage, so write it only while the block idles.
// A command accepted into the first stage passes the divide, point and output
// registers to out_tvalid. Throughput: one command per clock unless out_tready
// stalls, set by the path state update in the first stage; the divide by three
// is a 32x32 reciprocal multiply registered before the quotient is used.
// Each stage holds its item while the next is full, empty stages fill up, so
// in_tready stays high until all four stages are occupied by a stalled output.
// Reset clears the current point, subpath start, last control point and all
// valid bits and sets flip_y to 1.
`default_nettype none

module svg_path_to_cubic_bezier (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
  input  wire logic [spcb_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type[2:0], relative
  input  wire logic [spcb_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  output logic [spcb_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_wr_data
);
  import spcb_pkg::*;

  localparam int W = COORD_W;

  logic   flip_y_r;
  logic   s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic   rdy2, rdy3, rdy4, take;
  item_t  item_r, item_nxt;
  div_t   div_r, div_nxt;
  seg_t   pts_r, pts_nxt, f_seg;
  logic   f_emit;
  logic [OUT_TDATA_W-1:0] out_r, out_nxt;

  assign rdy4      = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign in_tready = !s1_v_r || rdy2;
  assign take      = s1_v_r && rdy2;

  always_comb begin
    item_nxt.req_type = in_tuser[2:0];
    item_nxt.relative = in_tuser[3];
    item_nxt.ctrl1_x  = in_tdata[0*W +: W];
    item_nxt.ctrl1_y  = in_tdata[1*W +: W];
    item_nxt.ctrl2_x  = in_tdata[2*W +: W];
    item_nxt.ctrl2_y  = in_tdata[3*W +: W];
    item_nxt.end_x    = in_tdata[4*W +: W];
    item_nxt.end_y    = in_tdata[5*W +: W];
  end

  spcb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .take  (take),
    .seg   (f_seg),
    .emit  (f_emit)
  );

  spcb_div3 u_div3 (
    .seg (f_seg),
    .div (div_nxt)
  );

  spcb_line u_line (
    .div (div_r),
    .seg (pts_nxt)
  );

  always_comb begin
    out_nxt[0*W +: W] = pts_r.ax;
    out_nxt[1*W +: W] = flip_y_r ? sat_sub('0, pts_r.ay) : pts_r.ay;
    out_nxt[2*W +: W] = pts_r.p1x;
    out_nxt[3*W +: W] = flip_y_r ? sat_sub('0, pts_r.p1y) : pts_r.p1y;
    out_nxt[4*W +: W] = pts_r.p2x;
    out_nxt[5*W +: W] = flip_y_r ? sat_sub('0, pts_r.p2y) : pts_r.p2y;
    out_nxt[6*W +: W] = pts_r.bx;
    out_nxt[7*W +: W] = flip_y_r ? sat_sub('0, pts_r.by) : pts_r.by;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_y_r <= 1'b1;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        flip_y_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r && f_emit;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      item_r <= item_nxt;
    end
    if (rdy2) begin
      div_r <= div_nxt;
    end
    if (rdy3) begin
      pts_r <= pts_nxt;
    end
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> flip_y_r && !out_tvalid && !s1_v_r)
    else $error("reset did not clear pipeline or set flip_y");

  a_no_emit_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !f_emit) |=> !s2_v_r)
    else $error("command without a segment entered the pipeline");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule

`default_nettype wire
